// ===== hdl/lsb_text_steganography_top_defines.svh =====
// assertion macros shared by the checker
`ifndef LSB_TEXT_STEGANOGRAPHY_TOP_DEFINES_SVH
`define LSB_TEXT_STEGANOGRAPHY_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSBSTEG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LSBSTEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lsbsteg_pkg.sv =====
`default_nettype none

package lsbsteg_pkg;

  localparam int unsigned POS_W      = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned BIT_IDX_W  = 3;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 13;

  localparam logic [DIM_W-1:0]   MAX_DIM      = 13'd4096;
  localparam logic [PLANE_W:0]   NUM_PLANES   = 3'd3;
  localparam logic [CHAR_W-1:0]  TERMINATOR   = 8'd13;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] character;
    logic [7:0]        sample;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         sample_out;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [PLANE_W-1:0] channel;
    logic               bit_used;
    logic [CHAR_W-1:0]  char_out;
    logic               char_valid;
    logic               finished;
    logic               out_of_space;
  } res_t;

  // position tracker state, plus a flag for the last sample of the last plane
  typedef struct packed {
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [PLANE_W-1:0] plane;
    logic               stopped;
    logic               last;
  } pos_t;

endpackage

`default_nettype wire

// ===== hdl/lsbsteg_pos.sv =====
`default_nettype none

module lsbsteg_pos import lsbsteg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [DIM_W-1:0] image_width,
  input  wire logic [DIM_W-1:0] image_height,
  output pos_t                  pos
);

  logic [POS_W-1:0]   column;
  logic [POS_W-1:0]   row;
  logic [PLANE_W-1:0] plane;
  logic               stopped;

  logic [DIM_W-1:0]   width_eff;
  logic [DIM_W-1:0]   height_eff;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic [PLANE_W:0]   plane_inc;
  logic               col_wrap;
  logic               row_wrap;
  logic               plane_wrap;

  // zero acts as one, oversize acts as the largest dimension
  always_comb begin
    if (image_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (image_width > MAX_DIM) begin
      width_eff = MAX_DIM;
    end else begin
      width_eff = image_width;
    end
    if (image_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (image_height > MAX_DIM) begin
      height_eff = MAX_DIM;
    end else begin
      height_eff = image_height;
    end
  end

  assign col_inc    = {1'b0, column} + DIM_W'(1);
  assign row_inc    = {1'b0, row} + DIM_W'(1);
  assign plane_inc  = {1'b0, plane} + (PLANE_W+1)'(1);
  assign col_wrap   = col_inc >= width_eff;
  assign row_wrap   = row_inc >= height_eff;
  assign plane_wrap = plane_inc >= NUM_PLANES;

  always_ff @(posedge clk) begin
    if (rst) begin
      column  <= '0;
      row     <= '0;
      plane   <= '0;
      stopped <= 1'b0;
    end else if (advance) begin
      if (!col_wrap) begin
        column <= col_inc[POS_W-1:0];
      end else begin
        column <= '0;
        if (!row_wrap) begin
          row <= row_inc[POS_W-1:0];
        end else begin
          row <= '0;
          if (!plane_wrap) begin
            plane <= plane_inc[PLANE_W-1:0];
          end else begin
            plane   <= '0;
            stopped <= 1'b1;
          end
        end
      end
    end
  end

  assign pos.column  = column;
  assign pos.row     = row;
  assign pos.plane   = plane;
  assign pos.stopped = stopped;
  assign pos.last    = col_wrap && row_wrap && plane_wrap;

endmodule

`default_nettype wire

// ===== hdl/lsb_text_steganography_top.sv =====
// LSB text hiding/recovery on a stream of image samples. Each item is either a
// character load (operation 0, no result) or a cover sample (operation 1, one
// result). Samples arrive column fastest, then row, then colour plane; the block
// keeps the position itself. One item is accepted per cycle while cmd_ready is
// high; a sample's result sits in the output register the cycle after it is
// accepted, and a new item is taken whenever that register is empty or being
// drained in the same cycle. The throughput is set by that single output
// register. After the last sample of the third plane the block reports
// out_of_space and passes samples through unchanged until reset. Write mode,
// image_width and image_height only while the block is idle.
`default_nettype none

module lsb_text_steganography_top import lsbsteg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cmd_t                 cmd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic                 mode;
  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;

  logic [BIT_IDX_W-1:0] bit_index;
  logic [BIT_IDX_W-1:0] bit_index_next;
  logic [CHAR_W-1:0]    char_shift;
  logic [CHAR_W-1:0]    char_shift_next;
  logic                 char_loaded;
  logic                 char_loaded_next;
  res_t                 res_next;

  logic                 accept;
  logic                 is_sample;
  logic                 advance;
  logic [CHAR_W-1:0]    gathered;
  pos_t                 pos;

  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign is_sample = cmd.operation == OP_SAMPLE;
  assign advance   = accept && is_sample && !pos.stopped;

  lsbsteg_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_EMBED;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:   mode         <= cfg_data[0];
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    gathered            = char_shift;
    gathered[bit_index] = cmd.sample[0];
  end

  always_comb begin
    bit_index_next   = bit_index;
    char_shift_next  = char_shift;
    char_loaded_next = char_loaded;

    res_next              = '0;
    res_next.sample_out   = cmd.sample;
    res_next.out_of_space = 1'b1;

    unique case (cmd.operation)
      OP_LOAD: begin
        char_shift_next  = cmd.character;
        bit_index_next   = '0;
        char_loaded_next = 1'b1;
      end
      OP_SAMPLE: begin
        if (!pos.stopped) begin
          res_next.pos_x        = pos.column;
          res_next.pos_y        = pos.row;
          res_next.channel      = pos.plane;
          res_next.out_of_space = pos.last;
          if (mode == MODE_EMBED) begin
            if (char_loaded) begin
              res_next.sample_out = {cmd.sample[7:1], char_shift[bit_index]};
              res_next.bit_used   = 1'b1;
              bit_index_next      = bit_index + BIT_IDX_W'(1);
              if (bit_index == '1) begin
                char_loaded_next = 1'b0;
              end
            end
          end else begin
            char_shift_next   = gathered;
            res_next.bit_used = 1'b1;
            bit_index_next    = bit_index + BIT_IDX_W'(1);
            if (bit_index == '1) begin
              if (gathered == TERMINATOR) begin
                res_next.finished = 1'b1;
              end else begin
                res_next.char_out   = gathered;
                res_next.char_valid = 1'b1;
              end
            end
          end
          // running out of space drops any partial character
          if (pos.last) begin
            bit_index_next   = '0;
            char_loaded_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index   <= '0;
      char_shift  <= '0;
      char_loaded <= 1'b0;
    end else if (accept) begin
      bit_index   <= bit_index_next;
      char_shift  <= char_shift_next;
      char_loaded <= char_loaded_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && is_sample) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_sample) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lsbsteg_checker.sv =====
`default_nettype none
`include "lsb_text_steganography_top_defines.svh"

module lsbsteg_checker import lsbsteg_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire res_t res
);

  // a waiting result must not be disturbed
  `LSBSTEG_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

  // an empty output register always takes the next item
  `LSBSTEG_ASSERT_NOW(a_ready_when_empty, !res_valid, cmd_ready, "block stalled with no result pending")

  // a completed character comes from a sample that yielded a bit, and is one kind
  `LSBSTEG_ASSERT_NOW(a_char_kind, res_valid && (res.char_valid || res.finished), res.bit_used && !(res.char_valid && res.finished), "bad character completion flags")

  // the terminator is never shown as text
  `LSBSTEG_ASSERT_NOW(a_no_term_out, res_valid && res.char_valid, res.char_out != TERMINATOR, "terminator delivered as character")

endmodule

bind lsb_text_steganography_top lsbsteg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire
